### hw/rtl/t8ls_pkg.sv
// ----------------------------------------------------------------------------
// t8ls_pkg
// Shared types and constants for the top-8 logit selector: beat formats,
// the per-cell store entry and the control bundle broadcast along the chain.
// ----------------------------------------------------------------------------
package t8ls_pkg;

  // default configuration
  localparam int unsigned VocabMaxDef = 131072;
  localparam int unsigned TopKDef     = 8;

  // fixed field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned IndexW = 17;

  // score reported for a rank that never got a logit (most negative Q16.16)
  localparam logic signed [ValueW-1:0] EmptyValue = {1'b1, {(ValueW-1){1'b0}}};

  // input beat
  typedef struct packed {
    logic signed [ValueW-1:0] logit;
    logic                     is_last;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic signed [ValueW-1:0] top_value;
    logic [IndexW-1:0]        top_index;
    logic                     last_rank;
  } out_beat_t;

  // one slot of the ranking
  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
    logic [IndexW-1:0]        index;
  } entry_t;

  // chain-wide control
  typedef struct packed {
    logic insert;  // a new logit enters the ranking this cycle
    logic drain;   // the whole chain moves up one slot toward the head
  } chain_ctl_t;

endpackage

### hw/rtl/t8ls_cell.sv
// ----------------------------------------------------------------------------
// t8ls_cell
// One slot of the sorted chain. Compares the incoming logit against its own
// entry, and either keeps it, takes the new logit, takes its upper
// neighbor's entry (shift down on insert) or its lower neighbor's (drain).
// ----------------------------------------------------------------------------
module t8ls_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  t8ls_pkg::chain_ctl_t  ctl_i,
  input  t8ls_pkg::entry_t      new_i,
  input  t8ls_pkg::entry_t      above_i,
  input  logic                  above_hit_i,
  input  t8ls_pkg::entry_t      below_i,
  output t8ls_pkg::entry_t      entry_o,
  output logic                  hit_o
);

  logic                                 valid_q, valid_d;
  logic signed [t8ls_pkg::ValueW-1:0]   value_q, value_d;
  logic [t8ls_pkg::IndexW-1:0]          index_q, index_d;
  logic                                 hit;

  // new logit belongs at or above this slot; strict compare keeps ties stable
  assign hit = !valid_q || ($signed(new_i.value) > $signed(value_q));

  // slot update
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    index_d = index_q;
    if (ctl_i.drain) begin
      valid_d = below_i.valid;
      value_d = below_i.value;
      index_d = below_i.index;
    end else if (ctl_i.insert) begin
      if (above_hit_i) begin
        valid_d = above_i.valid;
        value_d = above_i.value;
        index_d = above_i.index;
      end else if (hit) begin
        valid_d = 1'b1;
        value_d = new_i.value;
        index_d = new_i.index;
      end
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    index_q <= index_d;
  end

  assign entry_o = '{valid: valid_q, value: value_q, index: index_q};
  assign hit_o   = hit;

endmodule

### hw/rtl/top8_logit_selector_top.sv
// ----------------------------------------------------------------------------
// top8_logit_selector_top
// Streaming top-K selection over a logit vector, built as a chain of
// compare-and-insert cells kept in descending order, drained from the head.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | beat
//  in      | in  | in_valid_i/in_stall_o | in_data_i  (logit, is_last)
//  out     | out | out_valid_o/out_stall_i | out_data_o (top_value, top_index, last_rank)
//
//  Logit beats of a vector are accepted one per cycle while in_stall_o is low.
//  After the is_last beat the chain drains TOP_K result beats from the head cell,
//  one per cycle while out_stall_i is low; input is stalled during the drain.
//  Reset empties every slot and clears the logit counter; draining leaves the
//  chain empty and ready for the next vector.
// ----------------------------------------------------------------------------
module top8_logit_selector_top #(
  parameter int unsigned VOCAB_MAX = t8ls_pkg::VocabMaxDef,
  parameter int unsigned TOP_K     = t8ls_pkg::TopKDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  t8ls_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output t8ls_pkg::out_beat_t  out_data_o
);

  localparam int unsigned CntW  = $clog2(VOCAB_MAX);
  localparam int unsigned RankW = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  drain_q, drain_d;
  logic [RankW-1:0]      rank_q, rank_d;
  logic                  in_acc, out_acc, rank_last;
  t8ls_pkg::chain_ctl_t  ctl;
  t8ls_pkg::entry_t      new_entry;
  t8ls_pkg::entry_t      empty_entry;
  t8ls_pkg::entry_t      cell_entry [TOP_K];
  logic                  cell_hit   [TOP_K];

  // handshakes
  assign in_stall_o  = drain_q;
  assign out_valid_o = drain_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign rank_last   = (rank_q == RankW'(TOP_K - 1));

  // chain control and the incoming entry
  assign ctl.insert  = in_acc;
  assign ctl.drain   = out_acc;
  assign new_entry   = '{valid: 1'b1, value: in_data_i.logit,
                         index: t8ls_pkg::IndexW'(cnt_q)};
  assign empty_entry = '{valid: 1'b0, value: t8ls_pkg::EmptyValue, index: '0};

  // row of cells, head at slot zero
  for (genvar g = 0; g < TOP_K; g++) begin : g_cell
    t8ls_pkg::entry_t above, below;
    logic             above_hit;
    if (g == 0) begin : g_head
      assign above     = empty_entry;
      assign above_hit = 1'b0;
    end else begin : g_mid
      assign above     = cell_entry[g-1];
      assign above_hit = cell_hit[g-1];
    end
    if (g == TOP_K - 1) begin : g_tail
      assign below = empty_entry;
    end else begin : g_inner
      assign below = cell_entry[g+1];
    end
    t8ls_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .new_i       (new_entry),
      .above_i     (above),
      .above_hit_i (above_hit),
      .below_i     (below),
      .entry_o     (cell_entry[g]),
      .hit_o       (cell_hit[g])
    );
  end

  // logit counter, drain flag and rank counter
  always_comb begin
    cnt_d   = cnt_q;
    drain_d = drain_q;
    rank_d  = rank_q;
    if (in_acc) begin
      if (in_data_i.is_last || (cnt_q == CntW'(VOCAB_MAX - 1))) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
      if (in_data_i.is_last) begin
        drain_d = 1'b1;
        rank_d  = '0;
      end
    end
    if (out_acc) begin
      if (rank_last) begin
        drain_d = 1'b0;
        rank_d  = '0;
      end else begin
        rank_d = rank_q + RankW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      drain_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      cnt_q   <= cnt_d;
      drain_q <= drain_d;
      rank_q  <= rank_d;
    end
  end

  // result beat straight from the head cell
  assign out_data_o.top_value = cell_entry[0].valid ? cell_entry[0].value
                                                    : t8ls_pkg::EmptyValue;
  assign out_data_o.top_index = cell_entry[0].valid ? cell_entry[0].index : '0;
  assign out_data_o.last_rank = rank_last;

  // a last logit starts a drain at rank zero
  a_drain_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.is_last |=> out_valid_o && (rank_q == '0))
    else $error("drain did not start at rank zero");

  // drain continues until the final rank is taken
  a_drain_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !rank_last |=> out_valid_o)
    else $error("drain ended early");

  // final rank ends the drain with an empty head
  a_drain_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && rank_last |=> !out_valid_o && !cell_entry[0].valid)
    else $error("drain did not end or chain not cleared");

endmodule
